>>> hw/rtl/circular_suffix_sort_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-gated assertion wrappers; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_SUFFIX_SORT_DEFINES_SVH
`define CIRCULAR_SUFFIX_SORT_DEFINES_SVH
`ifndef SYNTHESIS
`define CSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define CSS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define CSS_ASSERT(lbl, prop, msg)
`define CSS_NEVER(lbl, cond, msg)
`endif
`endif

>>> hw/rtl/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg
// Shared constants, sequencer states and control structs.
// ----------------------------------------------------------------------------
package css_pkg;
	localparam int MAX_BLOCK = 4096;
	localparam int ALPHABET  = 256;
	localparam int ADDR_W    = 12;
	localparam int LEN_W     = 13;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_INIT  = 9'b000000010,
		ST_SHIFT = 9'b000000100,
		ST_CLR   = 9'b000001000,
		ST_HIST  = 9'b000010000,
		ST_PSUM  = 9'b000100000,
		ST_SCAT  = 9'b001000000,
		ST_RENUM = 9'b010000000,
		ST_COPY  = 9'b100000000
	} state_t;

	typedef struct packed {
		state_t     st;
		logic [1:0] ph;
		logic       go;
		state_t     nxt;
	} cmd_t;

	typedef struct packed {
		logic start;
		logic last;
		logic more;
	} sts_t;
endpackage

>>> hw/rtl/css_if.sv
// ----------------------------------------------------------------------------
// css request / result channels
// Valid/ready channels carrying load/read requests and read results.
// ----------------------------------------------------------------------------
interface css_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  data_byte;
	logic        last;
	logic [11:0] rank_index;
	modport source (output valid, action, data_byte, last, rank_index, input ready);
	modport sink (input valid, action, data_byte, last, rank_index, output ready);
endinterface

interface css_res_if;
	logic        valid;
	logic        ready;
	logic [11:0] rotation_start;
	logic [12:0] block_length;
	logic        out_of_range;
	modport source (output valid, rotation_start, block_length, out_of_range, input ready);
	modport sink (input valid, rotation_start, block_length, out_of_range, output ready);
endinterface

>>> hw/rtl/css_ctrl.sv
// ----------------------------------------------------------------------------
// css_ctrl
// Sort sequencer: walks passes and per-element phases.
// ----------------------------------------------------------------------------
module css_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  css_pkg::sts_t sts,
	output css_pkg::cmd_t cmd
);
	import css_pkg::*;

	state_t     st_q;
	logic [1:0] ph_q;
	logic [1:0] ph_last;
	logic       go;
	state_t     nxt;

	always_comb begin
		unique case (st_q)
			ST_HIST, ST_SCAT, ST_RENUM: ph_last = 2'd3;
			ST_CLR:                     ph_last = 2'd0;
			default:                    ph_last = 2'd1;
		endcase
	end

	assign go = (st_q != ST_IDLE) && (ph_q == ph_last);

	always_comb begin
		nxt = st_q;
		if (sts.last) begin
			unique case (st_q)
				ST_INIT:  nxt = ST_CLR;
				ST_SHIFT: nxt = ST_CLR;
				ST_CLR:   nxt = ST_HIST;
				ST_HIST:  nxt = ST_PSUM;
				ST_PSUM:  nxt = ST_SCAT;
				ST_SCAT:  nxt = ST_RENUM;
				ST_RENUM: nxt = ST_COPY;
				ST_COPY:  nxt = sts.more ? ST_SHIFT : ST_IDLE;
				default:  nxt = st_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ph_q <= 2'd0;
		end else if (st_q == ST_IDLE) begin
			ph_q <= 2'd0;
			if (sts.start) st_q <= ST_INIT;
		end else if (go) begin
			ph_q <= 2'd0;
			st_q <= nxt;
		end else begin
			ph_q <= ph_q + 2'd1;
		end
	end

	assign cmd = '{st: st_q, ph: ph_q, go: go, nxt: nxt};
endmodule

>>> hw/rtl/css_dp.sv
// ----------------------------------------------------------------------------
// css_dp
// Block stores, index/count registers and the load/read port.
// ----------------------------------------------------------------------------
`include "circular_suffix_sort_defines.svh"
module css_dp (
	input  logic          clk,
	input  logic          arst_n,
	css_req_if.sink       req,
	css_res_if.source     res,
	input  css_pkg::cmd_t cmd,
	output css_pkg::sts_t sts
);
	import css_pkg::*;

	logic [7:0]  text_mem [MAX_BLOCK];
	logic [11:0] ord_mem  [MAX_BLOCK];
	logic [11:0] cls_mem  [MAX_BLOCK];
	logic [11:0] ncls_mem [MAX_BLOCK];
	logic [11:0] shf_mem  [MAX_BLOCK];
	logic [12:0] cnt_mem  [MAX_BLOCK];

	logic [7:0]  text_rd_q;
	logic [11:0] ord_rd_q, cls_rd_q, ncls_rd_q, shf_rd_q;
	logic [12:0] cnt_rd_q;

	logic [12:0] len_q, nclass_q, step_q, acc_q;
	logic        done_q;
	logic [11:0] idx_q, a_q, c_q, ca_q, pca_q, pca2_q, cur_q;

	logic        rd_s1, hit_s1;
	logic        out_v_q;
	logic [11:0] rot_q;
	logic [12:0] blen_q, blen_s1;
	logic        oor_q;

	logic        idle, acc_in;
	logic [12:0] eff_len;

	// memory ports
	logic [11:0] text_ra, ord_ra, cls_ra, ncls_ra, shf_ra, cnt_ra;
	logic        text_we, ord_we, cls_we, ncls_we, shf_we, cnt_we;
	logic [11:0] text_wa, ord_wa, cls_wa, ncls_wa, shf_wa, cnt_wa;
	logic [7:0]  text_wd;
	logic [11:0] ord_wd, cls_wd, ncls_wd, shf_wd;
	logic [12:0] cnt_wd;

	logic [13:0] p_sum, a2_sum;
	logic [11:0] p_mod, a2_mod, cur_new;
	logic [12:0] limit, scat_v, psum_v, step_nxt;
	logic        diff;

	assign idle    = (cmd.st == ST_IDLE);
	assign req.ready = idle && !rd_s1 && (!out_v_q || res.ready);
	assign acc_in  = req.valid && req.ready;
	assign eff_len = done_q ? 13'd0 : len_q;

	assign p_sum  = {2'b0, ord_rd_q} + {1'b0, len_q} - {1'b0, step_q};
	assign p_mod  = (p_sum >= {1'b0, len_q}) ? 12'(p_sum - {1'b0, len_q}) : p_sum[11:0];
	assign a2_sum = {2'b0, a_q} + {1'b0, step_q};
	assign a2_mod = (a2_sum >= {1'b0, len_q}) ? 12'(a2_sum - {1'b0, len_q}) : a2_sum[11:0];
	assign diff   = (idx_q != 12'd0) && ((ca_q != pca_q) || (cls_rd_q != pca2_q));
	assign cur_new = (idx_q == 12'd0) ? 12'd0 : cur_q + {11'd0, diff};
	assign scat_v = cnt_rd_q - 13'd1;
	assign psum_v = acc_q + cnt_rd_q;
	assign step_nxt = (step_q == 13'd0) ? 13'd1 : {step_q[11:0], 1'b0};

	assign limit = ((cmd.st == ST_CLR) || (cmd.st == ST_PSUM)) ? nclass_q : len_q;
	assign sts.last  = (cmd.st == ST_SCAT) ? (idx_q == 12'd0)
	                                       : ({1'b0, idx_q} == limit - 13'd1);
	assign sts.more  = step_nxt < len_q;
	assign sts.start = acc_in && (req.action == ACT_LOAD) && req.last;

	always_comb begin
		text_ra = idx_q;  ord_ra = idx_q;  cls_ra = shf_rd_q;
		ncls_ra = idx_q;  shf_ra = idx_q;  cnt_ra = idx_q;
		text_we = 1'b0;   ord_we = 1'b0;   cls_we = 1'b0;
		ncls_we = 1'b0;   shf_we = 1'b0;   cnt_we = 1'b0;
		text_wa = eff_len[11:0]; text_wd = req.data_byte;
		ord_wa = scat_v[11:0];   ord_wd = c_q;
		cls_wa = idx_q;          cls_wd = {4'd0, text_rd_q};
		ncls_wa = a_q;           ncls_wd = cur_new;
		shf_wa = idx_q;          shf_wd = idx_q;
		cnt_wa = idx_q;          cnt_wd = 13'd0;
		unique case (cmd.st)
			ST_IDLE: begin
				ord_ra  = req.rank_index;
				text_we = acc_in && (req.action == ACT_LOAD)
				          && (eff_len < 13'(MAX_BLOCK));
			end
			ST_INIT: begin
				cls_we = (cmd.ph == 2'd1);
				shf_we = (cmd.ph == 2'd1);
			end
			ST_SHIFT: begin
				shf_we = (cmd.ph == 2'd1);
				shf_wd = p_mod;
			end
			ST_CLR: cnt_we = 1'b1;
			ST_HIST: begin
				cnt_ra = cls_rd_q;
				cnt_wa = c_q;
				cnt_wd = cnt_rd_q + 13'd1;
				cnt_we = (cmd.ph == 2'd3);
			end
			ST_PSUM: begin
				cnt_wd = psum_v;
				cnt_we = (cmd.ph == 2'd1);
			end
			ST_SCAT: begin
				cnt_ra = cls_rd_q;
				cnt_wa = ca_q;
				cnt_wd = scat_v;
				cnt_we = (cmd.ph == 2'd3);
				ord_we = (cmd.ph == 2'd3);
			end
			ST_RENUM: begin
				cls_ra  = (cmd.ph == 2'd2) ? a2_mod : ord_rd_q;
				ncls_we = (cmd.ph == 2'd3);
			end
			ST_COPY: begin
				cls_wd = ncls_rd_q;
				cls_we = (cmd.ph == 2'd1);
			end
			default: ;
		endcase
	end

	// block stores
	always_ff @(posedge clk) begin
		if (text_we) text_mem[text_wa] <= text_wd;
		if (ord_we)  ord_mem[ord_wa]   <= ord_wd;
		if (cls_we)  cls_mem[cls_wa]   <= cls_wd;
		if (ncls_we) ncls_mem[ncls_wa] <= ncls_wd;
		if (shf_we)  shf_mem[shf_wa]   <= shf_wd;
		if (cnt_we)  cnt_mem[cnt_wa]   <= cnt_wd;
		text_rd_q <= text_mem[text_ra];
		ord_rd_q  <= ord_mem[ord_ra];
		cls_rd_q  <= cls_mem[cls_ra];
		ncls_rd_q <= ncls_mem[ncls_ra];
		shf_rd_q  <= shf_mem[shf_ra];
		cnt_rd_q  <= cnt_mem[cnt_ra];
	end

	// per-element scratch; SCAT keeps the source position in c_q, class in ca_q
	always_ff @(posedge clk) begin
		unique case (cmd.st)
			ST_HIST: if (cmd.ph == 2'd2) c_q <= cls_rd_q;
			ST_SCAT: begin
				if (cmd.ph == 2'd1) c_q  <= shf_rd_q;
				if (cmd.ph == 2'd2) ca_q <= cls_rd_q;
			end
			ST_RENUM: begin
				if (cmd.ph == 2'd1) a_q  <= ord_rd_q;
				if (cmd.ph == 2'd2) ca_q <= cls_rd_q;
				if (cmd.ph == 2'd3) begin
					cur_q  <= cur_new;
					pca_q  <= ca_q;
					pca2_q <= cls_rd_q;
				end
			end
			default: ;
		endcase
		if (cmd.st == ST_PSUM && cmd.ph == 2'd1) acc_q <= psum_v;
		else if (cmd.go && cmd.nxt == ST_PSUM && cmd.st != ST_PSUM) acc_q <= 13'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= 13'd0;
			done_q   <= 1'b0;
			idx_q    <= 12'd0;
			nclass_q <= 13'd0;
			step_q   <= 13'd0;
		end else if (idle) begin
			if (acc_in && req.action == ACT_LOAD) begin
				done_q <= 1'b0;
				len_q  <= (eff_len < 13'(MAX_BLOCK)) ? eff_len + 13'd1 : eff_len;
				if (req.last) begin
					idx_q    <= 12'd0;
					step_q   <= 13'd0;
					nclass_q <= 13'(ALPHABET);
				end
			end
		end else if (cmd.go) begin
			if (cmd.nxt == cmd.st)
				idx_q <= (cmd.st == ST_SCAT) ? idx_q - 12'd1 : idx_q + 12'd1;
			else
				idx_q <= (cmd.nxt == ST_SCAT) ? 12'(len_q - 13'd1) : 12'd0;
			if (cmd.st == ST_RENUM && cmd.nxt != ST_RENUM)
				nclass_q <= {1'b0, cur_new} + 13'd1;
			if (cmd.st == ST_COPY && cmd.nxt != ST_COPY) begin
				step_q <= step_nxt;
				if (cmd.nxt == ST_IDLE) done_q <= 1'b1;
			end
		end
	end

	// read path: one stage for the order store, then the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			rd_s1 <= acc_in && (req.action == ACT_READ);
			if (rd_s1) out_v_q <= 1'b1;
			else if (res.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		hit_s1  <= done_q && ({1'b0, req.rank_index} < len_q);
		blen_s1 <= len_q;
		if (rd_s1) begin
			rot_q  <= hit_s1 ? ord_rd_q : 12'd0;
			oor_q  <= !hit_s1;
			blen_q <= blen_s1;
		end
	end

	assign res.valid          = out_v_q;
	assign res.rotation_start = rot_q;
	assign res.block_length   = blen_q;
	assign res.out_of_range   = oor_q;

	`CSS_NEVER(a_ready_busy, req.ready && !idle, "request taken while sorting")
	`CSS_ASSERT(a_read_result, rd_s1 |-> ##1 out_v_q, "read lost before result register")
	`CSS_NEVER(a_len_max, len_q > 13'(MAX_BLOCK), "block length beyond capacity")
	`CSS_NEVER(a_idx_range, !idle && ({1'b0, idx_q} >= limit), "pass index out of range")
endmodule

>>> hw/rtl/circular_suffix_sort.sv
// ----------------------------------------------------------------------------
// circular_suffix_sort
// Loads a byte block and sorts its cyclic rotations by prefix doubling.
// ----------------------------------------------------------------------------
// channel | dir | carries
// req     | in  | action, data_byte, last, rank_index
// res     | out | rotation_start, block_length, out_of_range
//
// A read passes through rd_s1 and the order-store read register, then loads the
// result register. A load with last starts the sort. First round: byte setup,
// count clear over C = 256 classes, histogram, prefix sum, scatter, renumber, copy;
// each later round (step 1, 2, 4 and so on below n) runs a shift pass in place of
// the setup, C being the class count. req.ready is low during the sort, in the cycle
// after a read is taken, and while a result waits. Reset clears control state only.
// ----------------------------------------------------------------------------
module circular_suffix_sort (
	input logic   clk,
	input logic   arst_n,
	css_req_if.sink   req,
	css_res_if.source res
);
	import css_pkg::*;

	cmd_t cmd;   // sequencer state, phase and next pass
	sts_t sts;   // pass end, round continue, sort start

	css_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	css_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res),
		.cmd    (cmd),
		.sts    (sts)
	);
endmodule
